// File: hdl/ipt_pkg.sv
// Shared constants and types for the inverted page table.
// Row layout, field widths, request codes and the sequencer state type.
// No dependencies; compile first.
package ipt_pkg;

   // Table geometry
   localparam int TABLE_ROWS = 512;
   localparam int PID_BITS   = 20;
   localparam int ROW_IDX_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
   localparam logic [ROW_IDX_W-1:0] ROW_LAST = ROW_IDX_W'(TABLE_ROWS - 1);

   // Field widths fixed by the interface
   localparam int REQ_TYPE_W  = 2;
   localparam int PAGE_BITS   = 9;
   localparam int FRAME_BITS  = 9;
   localparam int OFFSET_BITS = 7;
   localparam int VADDR_W     = 16;
   localparam int PADDR_W     = 16;
   localparam int CFG_PID_W   = 20;

   // Row layout: pid in 31..12, page in 11..3, exec, read-only, valid
   localparam int PID_SHIFT      = 12;
   localparam int ROW_W          = PID_BITS + PID_SHIFT;
   localparam int ROW_PAGE_LSB   = 3;
   localparam int ROW_VALID_BIT  = 0;
   localparam int ROW_RDONLY_BIT = 1;
   localparam int ROW_EXEC_BIT   = 2;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_MAP       = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNMAP     = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TRANSLATE = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_NOP       = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_RESP
   } state_type;

endpackage

// File: hdl/ipt_if.sv
// Handshake channels of the inverted page table: request and response.
// Depends on ipt_pkg for field widths.
interface ipt_req_if;
   import ipt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [PAGE_BITS-1:0]    vpage;
   logic [FRAME_BITS-1:0]   pframe;
   logic                    read_only;
   logic                    exec_allowed;
   logic [VADDR_W-1:0]      vaddr;
   modport source (output valid, req_type, vpage, pframe, read_only,
                   exec_allowed, vaddr, input ready);
   modport sink   (input valid, req_type, vpage, pframe, read_only,
                   exec_allowed, vaddr, output ready);
endinterface

interface ipt_rsp_if;
   import ipt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic                 mapped;
   logic                 writeable;
   logic [PADDR_W-1:0]   paddr;
   modport source (output valid, found, mapped, writeable, paddr,
                   input ready);
   modport sink   (input valid, found, mapped, writeable, paddr,
                   output ready);
endinterface

// File: hdl/inverted_page_table.sv
// Top level of the inverted page table: sequencer, row compare, response register.
// Depends on ipt_pkg, ipt_if (ipt_req_if, ipt_rsp_if) and ipt_ram.
//
//  channel   dir  handshake            payload
//  req_bus   in   valid/ready          req_type, vpage, pframe,
//                                      read_only, exec_allowed, vaddr
//  rsp_bus   out  valid/ready          found, mapped, writeable, paddr
//  csr_*     in   csr_we (no wait)     csr_wdata = process id
//
// Sequence: map and no-op go from accept to the response state, which moves
// the result into the output register. Unmap and translate scan the table one
// row per cycle through the single RAM read port and one comparator, stopping
// at the first hit or the last row. The next item is taken once that is done.
// Reset: a clearing pass writes zero to every row with req_bus.ready low; csr
// writes are taken throughout.
// Stalls: one item at a time; a new item is accepted while the previous
// result still waits in the output register.
module inverted_page_table (
   input  logic                          clock,
   input  logic                          reset,
   ipt_req_if.sink                       req_bus,
   ipt_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [ipt_pkg::CFG_PID_W-1:0] csr_wdata
);
   import ipt_pkg::*;

   // Control state
   state_type               state_ff, state_in;
   logic [ROW_IDX_W-1:0]    issue_ff, issue_in;   // read address / clear address
   logic [CFG_PID_W-1:0]    pid_ff, pid_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Item and result payload
   logic [ROW_IDX_W-1:0]    chk_ff, chk_in;       // row now on the RAM read data
   logic [REQ_TYPE_W-1:0]   op_ff, op_in;
   logic [PAGE_BITS-1:0]    key_ff, key_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic                    res_found_ff, res_found_in;
   logic                    res_mapped_ff, res_mapped_in;
   logic                    res_wr_ff, res_wr_in;
   logic [ROW_IDX_W-1:0]    res_frame_ff, res_frame_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic                    rsp_mapped_ff, rsp_mapped_in;
   logic                    rsp_wr_ff, rsp_wr_in;
   logic [PADDR_W-1:0]      rsp_paddr_ff, rsp_paddr_in;

   // Handshake and RAM controls
   logic                    req_ready;
   logic                    req_fire;
   logic                    req_search;
   logic                    map_in_range;
   logic                    rsp_free;
   logic                    rsp_load;
   logic                    ram_we;
   logic [ROW_IDX_W-1:0]    ram_waddr;
   logic [ROW_W-1:0]        ram_wdata;
   logic [ROW_W-1:0]        rd_row;
   logic [ROW_W-1:0]        map_row;
   logic                    row_hit;

   assign req_fire   = req_bus.valid && req_ready;
   assign req_search = (req_bus.req_type == REQ_UNMAP) ||
                       (req_bus.req_type == REQ_TRANSLATE);
   assign map_in_range = {1'b0, req_bus.pframe} < (FRAME_BITS + 1)'(TABLE_ROWS);
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   // Row written by map, tagged with the current process id
   always_comb begin
      map_row = '0;
      map_row[ROW_W-1:PID_SHIFT] = pid_ff[PID_BITS-1:0];
      map_row[ROW_PAGE_LSB +: PAGE_BITS] = req_bus.vpage;
      map_row[ROW_EXEC_BIT]   = req_bus.exec_allowed;
      map_row[ROW_RDONLY_BIT] = req_bus.read_only;
      map_row[ROW_VALID_BIT]  = 1'b1;
   end

   // The one comparator: process and page of the row on the read port
   assign row_hit = (state_ff == ST_SEARCH) &&
                    (rd_row[ROW_W-1:PID_SHIFT] == pid_ff[PID_BITS-1:0]) &&
                    (rd_row[ROW_PAGE_LSB +: PAGE_BITS] == key_ff);

   ipt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_ROWS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (issue_ff),
      .rdata (rd_row)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (issue_ff == ROW_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) state_in = req_search ? ST_SEARCH : ST_RESP;
         end
         ST_SEARCH: begin
            if (row_hit || (chk_ff == ROW_LAST)) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = issue_ff;
      ram_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            // zero one row per cycle
            ram_we = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            // map writes at accept; out-of-range frames are dropped
            ram_we    = req_fire && (req_bus.req_type == REQ_MAP) && map_in_range;
            ram_waddr = req_bus.pframe[ROW_IDX_W-1:0];
            ram_wdata = map_row;
         end
         ST_SEARCH: begin
            // unmap: clear the valid bit of the first hit
            ram_we    = row_hit && (op_ff == REQ_UNMAP);
            ram_waddr = chk_ff;
            ram_wdata = rd_row & ~(ROW_W'(1) << ROW_VALID_BIT);
         end
         ST_RESP: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      issue_in      = '0;
      chk_in        = issue_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      offset_in     = offset_ff;
      res_found_in  = res_found_ff;
      res_mapped_in = res_mapped_ff;
      res_wr_in     = res_wr_ff;
      res_frame_in  = res_frame_ff;
      pid_in        = csr_we ? csr_wdata : pid_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (issue_ff != ROW_LAST) issue_in = issue_ff + ROW_IDX_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               // row 0 is already on the read port; fetch row 1 next
               if (req_search) issue_in = ROW_IDX_W'(1);
               chk_in        = '0;
               op_in         = req_bus.req_type;
               key_in        = (req_bus.req_type == REQ_TRANSLATE) ?
                               req_bus.vaddr[VADDR_W-1 -: PAGE_BITS] :
                               req_bus.vpage;
               offset_in     = req_bus.vaddr[OFFSET_BITS-1:0];
               res_found_in  = 1'b0;
               res_mapped_in = 1'b0;
               res_wr_in     = 1'b0;
               res_frame_in  = '0;
            end
         end
         ST_SEARCH: begin
            // advance, holding at the last row
            if (!(row_hit || (chk_ff == ROW_LAST))) begin
               issue_in = (issue_ff == ROW_LAST) ? issue_ff : issue_ff + ROW_IDX_W'(1);
            end
            if (row_hit && (op_ff == REQ_TRANSLATE)) begin
               res_found_in  = 1'b1;
               res_mapped_in = rd_row[ROW_VALID_BIT];
               res_wr_in     = !rd_row[ROW_RDONLY_BIT];
               res_frame_in  = chk_ff;
            end
         end
         ST_RESP: begin
            issue_in = '0;
         end
         default: begin
            issue_in = '0;
         end
      endcase

      rsp_found_in  = rsp_found_ff;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_wr_in     = rsp_wr_ff;
      rsp_paddr_in  = rsp_paddr_ff;
      rsp_valid_in  = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = res_found_ff;
         rsp_mapped_in = res_mapped_ff;
         rsp_wr_in     = res_wr_ff;
         rsp_paddr_in  = res_found_ff ?
                         {FRAME_BITS'(res_frame_ff), offset_ff} : '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         pid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pid_ff       <= pid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      offset_ff     <= offset_in;
      res_found_ff  <= res_found_in;
      res_mapped_ff <= res_mapped_in;
      res_wr_ff     <= res_wr_in;
      res_frame_ff  <= res_frame_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_wr_ff     <= rsp_wr_in;
      rsp_paddr_ff  <= rsp_paddr_in;
   end

   assign req_bus.ready     = req_ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.found     = rsp_found_ff;
   assign rsp_bus.mapped    = rsp_mapped_ff;
   assign rsp_bus.writeable = rsp_wr_ff;
   assign rsp_bus.paddr     = rsp_paddr_ff;

   // One item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request accepted while another item is in flight");

   // Read data during a scan belongs to the row issued in the cycle before
   a_scan_lag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && $past(state_ff) == ST_SEARCH) |->
         (chk_ff == $past(issue_ff)))
      else $error("scan compare index out of step with read address");

   // A result without a hit carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         (!rsp_mapped_ff && !rsp_wr_ff && rsp_paddr_ff == '0))
      else $error("miss result carries nonzero fields");

   // No table write while idle unless a map is being accepted
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && ram_we) |->
         (req_fire && req_bus.req_type == REQ_MAP))
      else $error("table written while idle without a map");

endmodule

// File: hdl/ipt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module ipt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
